>>> hdl/cst_pkg.sv
// Shared types, codes and character-class functions for the character stream tokenizer.
package cst_pkg;

  // Default longest word kept; longer words are cut and flagged.
  localparam int MAX_WORD_DEF = 32;

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 5;
  localparam int VALUE_W = 32;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_IDENT     = 5'd0;
  localparam logic [KIND_W-1:0] K_NUMBER    = 5'd1;
  localparam logic [KIND_W-1:0] K_KEYWORD0  = 5'd2;
  localparam logic [KIND_W-1:0] K_LBRACE    = 5'd12;
  localparam logic [KIND_W-1:0] K_RBRACE    = 5'd13;
  localparam logic [KIND_W-1:0] K_LPAREN    = 5'd14;
  localparam logic [KIND_W-1:0] K_RPAREN    = 5'd15;
  localparam logic [KIND_W-1:0] K_BACKSLASH = 5'd16;
  localparam logic [KIND_W-1:0] K_BAR       = 5'd17;
  localparam logic [KIND_W-1:0] K_DOT       = 5'd18;
  localparam logic [KIND_W-1:0] K_ASSIGN    = 5'd19;
  localparam logic [KIND_W-1:0] K_COLON     = 5'd20;
  localparam logic [KIND_W-1:0] K_SEMI      = 5'd21;
  localparam logic [KIND_W-1:0] K_RARROW    = 5'd22;
  localparam logic [KIND_W-1:0] K_DASH      = 5'd23;
  localparam logic [KIND_W-1:0] K_LARROW    = 5'd24;
  localparam logic [KIND_W-1:0] K_PLUS      = 5'd25;
  localparam logic [KIND_W-1:0] K_STAR      = 5'd26;
  localparam logic [KIND_W-1:0] K_SLASH     = 5'd27;
  localparam logic [KIND_W-1:0] K_PERCENT   = 5'd28;
  localparam logic [KIND_W-1:0] K_CARET     = 5'd29;

  // Character codes that take part in lookahead.
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

  // Keywords, first character in the top byte, unused bytes zero.
  localparam int NUM_KW = 10;
  localparam logic [23:0] KW_TEXT [NUM_KW] = '{
    "nat", "cmd", {"S", 16'h0}, {"Z", 16'h0}, "fix",
    {"is", 8'h0}, {"in", 8'h0}, "ret", "bnd", "dcl"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd3, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3
  };

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_COLON,
    HELD_DASH,
    HELD_LT
  } held_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FLUSH,
    S_IDENT,
    S_CHAR
  } state_t;

  // Source of the word loaded into the output register.
  typedef enum logic [2:0] {
    SRC_HELD,
    SRC_KW,
    SRC_NUM,
    SRC_IDENT,
    SRC_SYM
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
    src_t src;
    logic last;
    logic clear_held;
    logic char_step;
    logic clear_word;
    logic ident_start;
    logic ident_adv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic held_any;
    logic combo;
    logic need_flush;
    logic sym_emit;
    logic kw_hit;
    logic all_digits;
    logic last_char;
    logic slot_free;
  } stat_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } sym_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

  // Single-character symbols that give a token at once.
  function automatic sym_t sym_kind(input logic [CHAR_W-1:0] c);
    sym_t s;
    s.hit = 1'b1;
    unique case (c)
      8'h7B:   s.kind = K_LBRACE;
      8'h7D:   s.kind = K_RBRACE;
      8'h28:   s.kind = K_LPAREN;
      8'h29:   s.kind = K_RPAREN;
      8'h5C:   s.kind = K_BACKSLASH;
      8'h7C:   s.kind = K_BAR;
      8'h2E:   s.kind = K_DOT;
      8'h3B:   s.kind = K_SEMI;
      8'h2B:   s.kind = K_PLUS;
      8'h2A:   s.kind = K_STAR;
      8'h2F:   s.kind = K_SLASH;
      8'h25:   s.kind = K_PERCENT;
      8'h5E:   s.kind = K_CARET;
      default: begin
        s.hit  = 1'b0;
        s.kind = K_IDENT;
      end
    endcase
    return s;
  endfunction

  // Symbols that wait for one character of lookahead.
  function automatic held_t held_of(input logic [CHAR_W-1:0] c);
    held_t h;
    unique case (c)
      CH_COLON: h = HELD_COLON;
      CH_DASH:  h = HELD_DASH;
      CH_LT:    h = HELD_LT;
      default:  h = HELD_NONE;
    endcase
    return h;
  endfunction

  // Keyword match on the first three stored characters; len is 0 for long words.
  function automatic kw_t kw_match(input logic [2:0] len, input logic [CHAR_W-1:0] c0,
                                   input logic [CHAR_W-1:0] c1,
                                   input logic [CHAR_W-1:0] c2);
    kw_t r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len == KW_LEN[k] && c0 == KW_TEXT[k][23:16] &&
          (len < 3'd2 || c1 == KW_TEXT[k][15:8]) &&
          (len < 3'd3 || c2 == KW_TEXT[k][7:0])) begin
        r.hit = 1'b1;
        r.idx = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/char_stream_tokenizer.sv
// Top level of the character stream tokenizer: controller, datapath and checks.
//
// Channel  Dir  Payload                                          Framing
// s_*      in   tdata[7:0] char_code                             tlast = end_mark
// m_*      out  tdata[4:0] kind, [36:5] value, [37] word_end,    tlast = last
//               [38] truncated, [39] zero
//
// One input word at a time. A word character, space or symbol passes through S_IDLE and
// S_DECODE; a character that follows a held symbol also passes through S_CHAR unless it
// completes a pair. Closing a word passes through S_FLUSH and S_CHAR for a keyword or
// number; an identifier also stays in S_IDENT, with one word-store read per output
// character. The output register refills in the cycle it is taken, so a stalled
// m_tready holds the sequencer in place and nothing is lost.
// Reset (rst, synchronous) empties the open word and the held symbol.
module char_stream_tokenizer #(
  parameter int MAX_WORD = cst_pkg::MAX_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [4:0] token_kind, [36:5] token_value, [37] word_end,
                                 // [38] truncated, [39] zero
  output logic        m_tlast
);

  cst_pkg::cmd_t  cmd;
  cst_pkg::stat_t status;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cst_dpath #(
    .MAX_WORD (MAX_WORD)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A result is loaded only when the output register is free or being drained.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.slot_free)
    else $error("result loaded over a pending output word");

  // Only one input word is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous word still in work");

  // An identifier walk always produces a result in each advancing cycle.
  a_ident_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.ident_adv |-> (cmd.emit && cmd.src == cst_pkg::SRC_IDENT))
    else $error("identifier index advanced without a result");

endmodule

>>> hdl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cst_ctrl.sv
// Controller state machine that sequences held symbols, word flushes and characters.
module cst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cst_pkg::stat_t status,
  output cst_pkg::cmd_t  cmd
);

  cst_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cst_pkg::S_IDLE: begin
        if (s_tvalid) state_next = cst_pkg::S_DECODE;
      end
      cst_pkg::S_DECODE: begin
        if (status.held_any) begin
          if (status.slot_free) begin
            if (status.combo) state_next = cst_pkg::S_IDLE;
            else if (status.need_flush) state_next = cst_pkg::S_FLUSH;
            else state_next = cst_pkg::S_CHAR;
          end
        end else if (status.need_flush) begin
          state_next = cst_pkg::S_FLUSH;
        end else if (!status.sym_emit || status.slot_free) begin
          state_next = cst_pkg::S_IDLE;
        end
      end
      cst_pkg::S_FLUSH: begin
        if (status.kw_hit || status.all_digits) begin
          if (status.slot_free) state_next = cst_pkg::S_CHAR;
        end else begin
          state_next = cst_pkg::S_IDENT;
        end
      end
      cst_pkg::S_IDENT: begin
        if (status.slot_free && status.last_char) state_next = cst_pkg::S_CHAR;
      end
      cst_pkg::S_CHAR: begin
        if (!status.sym_emit || status.slot_free) state_next = cst_pkg::S_IDLE;
      end
      default: state_next = cst_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd      = '0;
    cmd.src  = cst_pkg::SRC_HELD;
    s_tready = 1'b0;
    unique case (state)
      cst_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      cst_pkg::S_DECODE: begin
        if (status.held_any) begin
          cmd.emit       = status.slot_free;
          cmd.src        = cst_pkg::SRC_HELD;
          cmd.last       = status.combo || (!status.need_flush && !status.sym_emit);
          cmd.clear_held = status.slot_free;
        end else if (!status.need_flush) begin
          cmd.emit      = status.sym_emit && status.slot_free;
          cmd.src       = cst_pkg::SRC_SYM;
          cmd.last      = 1'b1;
          cmd.char_step = !status.sym_emit || status.slot_free;
        end
      end
      cst_pkg::S_FLUSH: begin
        if (status.kw_hit || status.all_digits) begin
          cmd.emit       = status.slot_free;
          cmd.src        = status.kw_hit ? cst_pkg::SRC_KW : cst_pkg::SRC_NUM;
          cmd.last       = !status.sym_emit;
          cmd.clear_word = status.slot_free;
        end else begin
          cmd.ident_start = 1'b1;
        end
      end
      cst_pkg::S_IDENT: begin
        cmd.emit       = status.slot_free;
        cmd.src        = cst_pkg::SRC_IDENT;
        cmd.last       = status.last_char && !status.sym_emit;
        cmd.ident_adv  = status.slot_free;
        cmd.clear_word = status.slot_free && status.last_char;
      end
      cst_pkg::S_CHAR: begin
        cmd.emit      = status.sym_emit && status.slot_free;
        cmd.src       = cst_pkg::SRC_SYM;
        cmd.last      = 1'b1;
        cmd.char_step = !status.sym_emit || status.slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/cst_dpath.sv
// Datapath: input latch, word store, number accumulator, held symbol and output register.
module cst_dpath #(
  parameter int MAX_WORD = cst_pkg::MAX_WORD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 s_tdata,
  input  logic                       s_tlast,
  input  cst_pkg::cmd_t              cmd,
  output cst_pkg::stat_t             status,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [39:0]                m_tdata,
  output logic                       m_tlast
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);

  // Latched input word.
  logic [cst_pkg::CHAR_W-1:0] ch;
  logic                       endm;

  // Lexer state.
  cst_pkg::held_t              held;
  logic [LW-1:0]               word_length;
  logic                        all_digits;
  logic [cst_pkg::VALUE_W-1:0] acc;
  logic                        overflowed;
  logic [cst_pkg::CHAR_W-1:0]  c0, c1, c2;
  logic [LW-1:0]               idx;

  // Output register.
  logic                        out_valid;
  logic [cst_pkg::KIND_W-1:0]  out_kind;
  logic [cst_pkg::VALUE_W-1:0] out_value;
  logic                        out_wend;
  logic                        out_trunc;
  logic                        out_last;

  // Decode of the latched character.
  cst_pkg::sym_t              sym;
  cst_pkg::held_t             hc;
  cst_pkg::kw_t               kw;
  logic [2:0]                 short_len;
  logic                       combo;
  logic [cst_pkg::KIND_W-1:0] held_kind;
  logic                       appending;
  logic [35:0]                acc_sum;
  logic [cst_pkg::CHAR_W-1:0] rd_char;
  logic [AW-1:0]              raddr;
  logic [LW-1:0]              idx_inc;

  logic [cst_pkg::KIND_W-1:0]  emit_kind;
  logic [cst_pkg::VALUE_W-1:0] emit_value;
  logic                        emit_wend;
  logic                        emit_trunc;

  assign sym       = cst_pkg::sym_kind(ch);
  assign hc        = cst_pkg::held_of(ch);
  assign short_len = (word_length > LW'(3)) ? 3'd0 : word_length[2:0];
  assign kw        = cst_pkg::kw_match(short_len, c0, c1, c2);
  assign idx_inc   = idx + LW'(1);

  // A held symbol pairs with the next character into a two-character token.
  assign combo = !endm && ((held == cst_pkg::HELD_COLON && ch == cst_pkg::CH_EQ) ||
                           (held == cst_pkg::HELD_DASH && ch == cst_pkg::CH_GT) ||
                           (held == cst_pkg::HELD_LT && ch == cst_pkg::CH_DASH));

  always_comb begin
    unique case (held)
      cst_pkg::HELD_COLON: held_kind = combo ? cst_pkg::K_ASSIGN : cst_pkg::K_COLON;
      cst_pkg::HELD_DASH:  held_kind = combo ? cst_pkg::K_RARROW : cst_pkg::K_DASH;
      default:             held_kind = combo ? cst_pkg::K_LARROW : cst_pkg::K_PLUS;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.held_any   = held != cst_pkg::HELD_NONE;
    status.combo      = combo;
    status.need_flush = (word_length != '0) && (endm || !cst_pkg::is_word_char(ch));
    status.sym_emit   = !endm && sym.hit;
    status.kw_hit     = kw.hit && !overflowed;
    status.all_digits = all_digits;
    status.last_char  = idx_inc == word_length;
    status.slot_free  = !out_valid || m_tready;
  end

  // A character that is neither space nor symbol joins the open word.
  assign appending = cmd.char_step && !endm && !sym.hit && hc == cst_pkg::HELD_NONE &&
                     !cst_pkg::is_space(ch);

  // acc * 10 + digit, in 36 bits for the saturation test.
  assign acc_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'h0, ch[3:0]};

  // Word character store.
  always_comb begin
    if (cmd.ident_start) raddr = '0;
    else if (cmd.ident_adv) raddr = idx_inc[AW-1:0];
    else raddr = idx[AW-1:0];
  end

  cst_ram #(
    .WIDTH (cst_pkg::CHAR_W),
    .DEPTH (MAX_WORD)
  ) u_word_ram (
    .clk   (clk),
    .we    (appending && word_length != LW'(MAX_WORD)),
    .waddr (word_length[AW-1:0]),
    .wdata (ch),
    .raddr (raddr),
    .rdata (rd_char)
  );

  // Input latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch   <= s_tdata;
      endm <= s_tlast;
    end
  end

  // Held symbol.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= cst_pkg::HELD_NONE;
    end else if (cmd.clear_held) begin
      held <= cst_pkg::HELD_NONE;
    end else if (cmd.char_step && !endm && hc != cst_pkg::HELD_NONE) begin
      held <= hc;
    end
  end

  // Open word: length, class, number value and overflow.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_word) begin
      word_length <= '0;
      all_digits  <= 1'b1;
      acc         <= '0;
      overflowed  <= 1'b0;
    end else if (appending) begin
      if (word_length == LW'(MAX_WORD)) begin
        overflowed <= 1'b1;
      end else begin
        word_length <= word_length + LW'(1);
        if (!cst_pkg::is_digit(ch)) begin
          all_digits <= 1'b0;
        end else if (all_digits) begin
          acc <= (acc_sum[35:32] != 4'h0) ? '1 : acc_sum[31:0];
        end
      end
    end
  end

  // First three characters for keyword matching.
  always_ff @(posedge clk) begin
    if (appending) begin
      if (word_length == LW'(0)) c0 <= ch;
      if (word_length == LW'(1)) c1 <= ch;
      if (word_length == LW'(2)) c2 <= ch;
    end
  end

  // Identifier read index.
  always_ff @(posedge clk) begin
    if (cmd.ident_start) begin
      idx <= '0;
    end else if (cmd.ident_adv) begin
      idx <= idx_inc;
    end
  end

  // Result selection.
  always_comb begin
    emit_kind  = cst_pkg::K_IDENT;
    emit_value = '0;
    emit_wend  = 1'b0;
    emit_trunc = 1'b0;
    unique case (cmd.src)
      cst_pkg::SRC_HELD: emit_kind = held_kind;
      cst_pkg::SRC_KW:   emit_kind = cst_pkg::K_KEYWORD0 + cst_pkg::KIND_W'(kw.idx);
      cst_pkg::SRC_NUM: begin
        emit_kind  = cst_pkg::K_NUMBER;
        emit_value = acc;
        emit_trunc = overflowed;
      end
      cst_pkg::SRC_IDENT: begin
        emit_kind  = cst_pkg::K_IDENT;
        emit_value = {24'h0, rd_char};
        emit_wend  = status.last_char;
        emit_trunc = overflowed;
      end
      cst_pkg::SRC_SYM:  emit_kind = sym.kind;
      default:           emit_kind = cst_pkg::K_IDENT;
    endcase
  end

  // Output register; it refills in the cycle its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= emit_kind;
      out_value <= emit_value;
      out_wend  <= emit_wend;
      out_trunc <= emit_trunc;
      out_last  <= cmd.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_trunc, out_wend, out_value, out_kind};
  assign m_tlast  = out_last;

endmodule
